FILE: rtl/core/lpt_pkg.sv
package lpt_pkg;

  // Fixed field widths of the request and result payloads
  localparam int unsigned KEY_W     = 32;
  localparam int unsigned SLOT_W    = 3;
  localparam int unsigned CAP_W     = 4;
  localparam logic [CAP_W-1:0] CAP_RESET = 4'd8;

  typedef enum logic {
    CMD_TOUCH   = 1'b0,
    CMD_RELEASE = 1'b1
  } cmd_e;

  typedef struct packed {
    cmd_e             command;
    logic [KEY_W-1:0] key;
  } req_t;

  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic              evicted;
    logic [KEY_W-1:0]  evicted_key;
  } res_t;

endpackage

FILE: rtl/core/lpt_lookup.sv
module lpt_lookup #(
  parameter int unsigned DEPTH = 8,
  parameter int unsigned SW    = 32,
  localparam int unsigned AW   = $clog2(DEPTH),
  localparam int unsigned CW   = $clog2(DEPTH + 1)
) (
  input  logic [DEPTH-1:0]         valid_i,
  input  logic [DEPTH-1:0][AW-1:0] age_i,
  input  logic [DEPTH-1:0][SW-1:0] key_i,
  input  logic [SW-1:0]            probe_i,
  output logic [DEPTH-1:0]         hit_oh_o,
  output logic [DEPTH-1:0]         lru_oh_o,
  output logic [DEPTH-1:0]         free_oh_o,
  output logic [CW-1:0]            count_o
);

  logic [DEPTH-1:0] match;
  logic [CW-1:0]    count;
  logic [AW-1:0]    oldest;

  // Tag compare and occupancy count
  always_comb begin
    count = '0;
    for (int i = 0; i < DEPTH; i++) begin
      match[i] = valid_i[i] && (key_i[i] == probe_i);
      count    = count + CW'(valid_i[i]);
    end
  end

  // Valid ages are the ranks 0..count-1, so the oldest rank is count-1
  assign oldest = AW'(count - CW'(1));

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      lru_oh_o[i] = valid_i[i] && (age_i[i] == oldest);
    end
  end

  // Lowest set bit of the match vector, lowest clear bit of the valid vector
  assign hit_oh_o  = match & (~match + DEPTH'(1));
  assign free_oh_o = ~valid_i & (valid_i + DEPTH'(1));
  assign count_o   = count;

endmodule

FILE: rtl/core/lru_pool_tag_table_top.sv
// Channel  | Ports                              | Handshake
// ---------+------------------------------------+------------------------------------
// request  | start_i, busy_o, req_i (req_t)     | taken on an edge with start_i & !busy_o
// result   | done_o, res_o (res_t)              | done_o high for one cycle, no stall
// config   | cfg_we_i, cfg_wdata_i              | capacity written on an edge with cfg_we_i
//
// One request per cycle; busy_o never rises. A request is captured in the input
// register, where the tag compare and age update run against the table, and its
// result appears on res_o the cycle after that, with done_o.
// rst_ni (async, active low) empties the table and sets capacity to 8.
// The receiver cannot stall, so there is no output back-pressure to handle.
module lru_pool_tag_table_top
  import lpt_pkg::*;
#(
  parameter int unsigned DEPTH     = 8,
  parameter int unsigned KEY_WIDTH = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  output logic             busy_o,
  input  req_t             req_i,
  output logic             done_o,
  output res_t             res_o,
  input  logic             cfg_we_i,
  input  logic [CAP_W-1:0] cfg_wdata_i
);

  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CW    = $clog2(DEPTH + 1);
  localparam int unsigned SW    = (KEY_WIDTH < KEY_W) ? KEY_WIDTH : KEY_W;
  localparam int unsigned CMP_W = (CW > CAP_W) ? CW : CAP_W;

  // Capacity register
  logic [CAP_W-1:0] cap_q;

  // Input register
  logic             in_vld_q;
  cmd_e             in_cmd_q;
  logic [SW-1:0]    in_key_q;

  // Table state
  logic [DEPTH-1:0]         valid_q, valid_d;
  logic [DEPTH-1:0][AW-1:0] age_q, age_d;
  logic [DEPTH-1:0][SW-1:0] key_q;

  // Result register
  logic done_q;
  res_t res_q, res_d;

  // Lookup outputs
  logic [DEPTH-1:0] hit_oh, lru_oh, free_oh, tgt_oh;
  logic [CW-1:0]    count;

  logic             hit, full, key_we;
  logic [CMP_W-1:0] cap_ext, eff_cap;
  logic [AW-1:0]    hit_age, hit_idx, tgt_idx;
  logic [SW-1:0]    lru_key;

  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (cfg_we_i) begin
      cap_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      in_cmd_q <= req_i.command;
      in_key_q <= req_i.key[SW-1:0];
    end
  end

  lpt_lookup #(
    .DEPTH (DEPTH),
    .SW    (SW)
  ) u_lookup (
    .valid_i   (valid_q),
    .age_i     (age_q),
    .key_i     (key_q),
    .probe_i   (in_key_q),
    .hit_oh_o  (hit_oh),
    .lru_oh_o  (lru_oh),
    .free_oh_o (free_oh),
    .count_o   (count)
  );

  // Effective capacity: zero counts as one, anything above DEPTH saturates
  assign cap_ext = CMP_W'(cap_q);
  always_comb begin
    if (cap_q == '0) begin
      eff_cap = CMP_W'(1);
    end else if (cap_ext > CMP_W'(DEPTH)) begin
      eff_cap = CMP_W'(DEPTH);
    end else begin
      eff_cap = cap_ext;
    end
  end

  assign hit    = |hit_oh;
  assign full   = CMP_W'(count) >= eff_cap;
  // On a miss: reuse the least recent slot when full, else the lowest free one
  assign tgt_oh = full ? lru_oh : free_oh;

  // One-hot selects: index, age and evicted key
  always_comb begin
    hit_age = '0;
    hit_idx = '0;
    tgt_idx = '0;
    lru_key = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (hit_oh[i]) begin
        hit_age = hit_age | age_q[i];
        hit_idx = hit_idx | AW'(i);
      end
      if (tgt_oh[i]) begin
        tgt_idx = tgt_idx | AW'(i);
      end
      if (lru_oh[i]) begin
        lru_key = lru_key | key_q[i];
      end
    end
  end

  // Table update; ages of valid entries always form the ranks 0..count-1
  always_comb begin
    valid_d = valid_q;
    age_d   = age_q;
    key_we  = 1'b0;
    if (in_vld_q) begin
      unique case (in_cmd_q)
        CMD_RELEASE: begin
          if (hit) begin
            for (int i = 0; i < DEPTH; i++) begin
              if (hit_oh[i]) begin
                valid_d[i] = 1'b0;
                age_d[i]   = '0;
              end else if (valid_q[i] && (age_q[i] > hit_age)) begin
                age_d[i] = age_q[i] - AW'(1);
              end
            end
          end
        end
        CMD_TOUCH: begin
          if (hit) begin
            for (int i = 0; i < DEPTH; i++) begin
              if (hit_oh[i]) begin
                age_d[i] = '0;
              end else if (valid_q[i] && (age_q[i] < hit_age)) begin
                age_d[i] = age_q[i] + AW'(1);
              end
            end
          end else begin
            key_we = 1'b1;
            for (int i = 0; i < DEPTH; i++) begin
              if (tgt_oh[i]) begin
                valid_d[i] = 1'b1;
                age_d[i]   = '0;
              end else if (valid_q[i]) begin
                age_d[i] = age_q[i] + AW'(1);
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      age_q   <= '0;
    end else begin
      valid_q <= valid_d;
      age_q   <= age_d;
    end
  end

  // Key store: written only on a miss, no reset
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < DEPTH; i++) begin
      if (key_we && tgt_oh[i]) begin
        key_q[i] <= in_key_q;
      end
    end
  end

  // Result
  always_comb begin
    res_d             = '0;
    res_d.hit         = hit;
    if (hit) begin
      res_d.slot = SLOT_W'(hit_idx);
    end else if (in_cmd_q == CMD_TOUCH) begin
      res_d.slot        = SLOT_W'(tgt_idx);
      res_d.evicted     = full;
      res_d.evicted_key = full ? KEY_W'(lru_key) : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_vld_q) begin
      res_q <= res_d;
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

FILE: bench/lru_pool_tag_table_top_test.sv
`timescale 1ns / 100ps

module lru_pool_tag_table_top_test;
  import lpt_pkg::*;

  localparam int unsigned DEPTH      = 8;
  localparam int unsigned KEY_WIDTH  = 32;
  localparam int unsigned CLK_PERIOD = 8;
  localparam int unsigned RST_CYCLES = 11;
  // Roughly 1500 requests with random gaps between bursts; the limit allows for
  // several times the run time they need.
  localparam int unsigned RUN_LIMIT_NS = 2_000_000;
  localparam int unsigned PHASE_ITEMS  = 140;
  localparam int unsigned N_PHASES     = 11;
  localparam int unsigned MAX_REPORTS  = 10;

  // DUT ports; every input starts at a known value
  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             start_i     = 1'b0;
  logic             busy_o;
  req_t             req_i       = '0;
  logic             done_o;
  res_t             res_o;
  logic             cfg_we_i    = 1'b0;
  logic [CAP_W-1:0] cfg_wdata_i = '0;

  // Requests waiting for the driver, and results the table should give back
  req_t request_q[$];
  res_t expected_res_q[$];

  // Shadow of the tag table: valid bits, tags and recency ranks (0 = newest)
  logic                 tbl_valid [DEPTH];
  logic [KEY_WIDTH-1:0] tbl_key   [DEPTH];
  logic [2:0]           tbl_age   [DEPTH];
  logic [CAP_W-1:0]     cap_model;

  // Capacity settings walked through by the random phases; zero and values
  // above the depth are clamped by the block
  logic [CAP_W-1:0] cap_plan [0:N_PHASES-1] =
    '{4'd1, 4'd0, 4'd15, 4'd3, 4'd8, 4'd5, 4'd2, 4'd9, 4'd7, 4'd4, 4'd8};

  // Sender pacing
  int burst_left = 1;
  int gap_left   = 0;

  // Bookkeeping
  int   n_fail         = 0;
  int   n_touch        = 0;
  int   n_release      = 0;
  int   n_hit          = 0;
  int   n_evict        = 0;
  int   n_cap_settings = 0;
  res_t want_res;
  res_t exp_res;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  lru_pool_tag_table_top #(
    .DEPTH     (DEPTH),
    .KEY_WIDTH (KEY_WIDTH)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .req_i       (req_i),
    .done_o      (done_o),
    .res_o       (res_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // Every valid entry older than the given rank moves one step newer.
  function automatic void close_age_gap(logic [2:0] rank);
    for (int i = 0; i < DEPTH; i++) begin
      if (tbl_valid[i] && tbl_age[i] > rank) tbl_age[i] = tbl_age[i] - 3'd1;
    end
  endfunction

  // Applies one request to the shadow table and returns the result it causes.
  function automatic res_t lru_table_predict(req_t r);
    res_t       o;
    int         found;
    int         n_valid;
    int         victim;
    int         eff_cap;
    logic [2:0] rank;
    o       = '0;
    found   = -1;
    n_valid = 0;
    victim  = -1;
    rank    = '0;
    eff_cap = (cap_model == 0) ? 1 : (cap_model > DEPTH) ? DEPTH : int'(cap_model);

    // Only valid entries take part in the tag compare; the first match wins
    for (int i = 0; i < DEPTH; i++) begin
      if (tbl_valid[i]) begin
        n_valid++;
        if (found < 0 && tbl_key[i] == r.key) found = i;
      end
    end

    if (r.command == CMD_RELEASE) begin
      // release of an absent tag leaves everything as it is, result all zero
      if (found >= 0) begin
        o.hit = 1'b1;
        o.slot = SLOT_W'(found);
        tbl_valid[found] = 1'b0;
        close_age_gap(tbl_age[found]);
        tbl_age[found] = '0;
      end
    end else if (found >= 0) begin
      // hit: entries newer than this one age by a step, this one goes to front
      rank = tbl_age[found];
      o.hit = 1'b1;
      o.slot = SLOT_W'(found);
      for (int i = 0; i < DEPTH; i++) begin
        if (tbl_valid[i] && tbl_age[i] < rank) tbl_age[i] = tbl_age[i] + 3'd1;
      end
      tbl_age[found] = '0;
    end else begin
      // miss at or above capacity: drop the oldest entry and reuse its slot;
      // with capacity lowered below the count only one entry goes per miss
      if (n_valid >= eff_cap) begin
        for (int i = 0; i < DEPTH; i++) begin
          if (tbl_valid[i] && (victim < 0 || tbl_age[i] > rank)) begin
            victim = i;
            rank = tbl_age[i];
          end
        end
        if (victim >= 0) begin
          o.evicted = 1'b1;
          o.evicted_key = tbl_key[victim];
          tbl_valid[victim] = 1'b0;
          close_age_gap(rank);
        end
      end
      // otherwise the lowest free slot
      if (victim < 0) begin
        for (int i = DEPTH - 1; i >= 0; i--) begin
          if (!tbl_valid[i]) victim = i;
        end
      end
      if (victim >= 0) begin
        for (int i = 0; i < DEPTH; i++) begin
          if (tbl_valid[i]) tbl_age[i] = tbl_age[i] + 3'd1;
        end
        tbl_valid[victim] = 1'b1;
        tbl_key[victim] = r.key;
        tbl_age[victim] = '0;
        o.slot = SLOT_W'(victim);
      end
    end
    return o;
  endfunction

  // Driver: takes requests from the queue in bursts of random length with
  // random gaps. A request counts as taken on an edge with start_i & !busy_o,
  // which is also where the shadow table is updated.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start_i <= 1'b0;
    end else begin
      if (start_i && !busy_o) begin
        want_res = lru_table_predict(req_i);
        expected_res_q.push_back(want_res);
        if (req_i.command == CMD_RELEASE) n_release++;
        else n_touch++;
        if (want_res.hit) n_hit++;
        if (want_res.evicted) n_evict++;
      end

      if (start_i && busy_o) begin
        // hold the request until the block takes it
      end else if (gap_left > 0) begin
        gap_left--;
        start_i <= 1'b0;
      end else if (request_q.size() != 0) begin
        req_i   <= request_q.pop_front();
        start_i <= 1'b1;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 24);
          // a quarter of bursts run straight on into the next
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left--;
        end
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // Monitor: done_o marks exactly one cycle, the receiver never stalls.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (expected_res_q.size() == 0) begin
        n_fail++;
        if (n_fail <= MAX_REPORTS)
          $display("[%0t] stray result: hit=%0d slot=%0d ev=%0d evkey=%08h",
                   $realtime, res_o.hit, res_o.slot, res_o.evicted, res_o.evicted_key);
      end else begin
        exp_res = expected_res_q.pop_front();
        if (res_o.hit !== exp_res.hit || res_o.slot !== exp_res.slot ||
            res_o.evicted !== exp_res.evicted ||
            res_o.evicted_key !== exp_res.evicted_key) begin
          n_fail++;
          if (n_fail <= MAX_REPORTS) begin
            $display("[%0t] mismatch: exp hit=%0d slot=%0d ev=%0d evkey=%08h",
                     $realtime, exp_res.hit, exp_res.slot, exp_res.evicted,
                     exp_res.evicted_key);
            $display("    got hit=%0d slot=%0d ev=%0d evkey=%08h",
                     res_o.hit, res_o.slot, res_o.evicted, res_o.evicted_key);
          end
        end
      end
    end
  end

  task automatic add_req(cmd_e cmd, logic [KEY_WIDTH-1:0] key);
    req_t r;
    r.command = cmd;
    r.key = key;
    request_q.push_back(r);
  endtask

  // Idle means nothing queued, nothing on the request port and no result owed.
  // Every request gives exactly one result, so once none is owed the table is idle.
  task automatic wait_idle();
    while (request_q.size() != 0 || start_i || expected_res_q.size() != 0)
      @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic set_capacity(logic [CAP_W-1:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i  <= 1'b0;
    cap_model = value;
    n_cap_settings++;
  endtask

  // Mostly tags from a pool a little larger than the capacity, so hits,
  // refreshes and evictions all happen; a few fresh random tags as noise.
  task automatic queue_random_phase(int n_items, int eff_cap, bit with_extremes);
    logic [KEY_WIDTH-1:0] pool[$];
    int                   n_keys;
    logic [KEY_WIDTH-1:0] key;
    n_keys = eff_cap + $urandom_range(1, 4);
    for (int k = 0; k < n_keys; k++) pool.push_back($urandom());
    if (with_extremes) begin
      pool.push_back('0);
      pool.push_back('1);
    end
    for (int n = 0; n < n_items; n++) begin
      if ($urandom_range(0, 99) < 8) key = $urandom();
      else key = pool[$urandom_range(0, pool.size() - 1)];
      add_req(($urandom_range(0, 99) < 20) ? CMD_RELEASE : CMD_TOUCH, key);
    end
  endtask

  // Phase sequencer
  initial begin
    int eff;
    for (int i = 0; i < DEPTH; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_key[i]   = '0;
      tbl_age[i]   = '0;
    end
    cap_model = CAP_RESET;

    repeat (RST_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty table, fill to the reset capacity, evict, free and refill
    add_req(CMD_RELEASE, 32'h0000_0000);  // release on an empty table
    add_req(CMD_TOUCH,   32'h0000_0000);
    add_req(CMD_TOUCH,   32'hFFFF_FFFF);
    add_req(CMD_TOUCH,   32'h0000_0000);  // hit, refreshes tag zero
    add_req(CMD_TOUCH,   32'h8000_0000);
    add_req(CMD_TOUCH,   32'h0000_0001);
    add_req(CMD_TOUCH,   32'h5555_5555);
    add_req(CMD_TOUCH,   32'hAAAA_AAAA);
    add_req(CMD_TOUCH,   32'h1234_5678);
    add_req(CMD_TOUCH,   32'hDEAD_BEEF);  // table now full
    add_req(CMD_TOUCH,   32'h0F0F_0F0F);  // miss at capacity, all-ones goes
    add_req(CMD_RELEASE, 32'hFFFF_FFFF);  // no longer present
    add_req(CMD_RELEASE, 32'h0000_0000);  // frees a slot
    add_req(CMD_TOUCH,   32'hF0F0_F0F0);  // takes the lowest free slot
    add_req(CMD_TOUCH,   32'h8000_0000);  // hit on the oldest entry
    add_req(CMD_RELEASE, 32'h0000_0001);
    wait_idle();

    // Capacity dropped well below the live count: one eviction per miss
    set_capacity(4'd2);
    add_req(CMD_TOUCH,   32'h7FFF_FFFF);
    add_req(CMD_TOUCH,   32'hFFFF_FFFE);
    add_req(CMD_TOUCH,   32'h5555_5555);
    add_req(CMD_RELEASE, 32'h7FFF_FFFF);
    add_req(CMD_TOUCH,   32'hFFFF_FFFE);
    wait_idle();

    // Random phases, one per capacity setting
    for (int p = 0; p < N_PHASES; p++) begin
      set_capacity(cap_plan[p]);
      eff = (cap_plan[p] == 0) ? 1 : (cap_plan[p] > DEPTH) ? DEPTH : int'(cap_plan[p]);
      queue_random_phase(PHASE_ITEMS, eff, p[0]);
      wait_idle();
    end

    // Drain: wait longer so any stray result is caught
    repeat (8) @(posedge clk_i);
    n_fail += expected_res_q.size();

    $display("Covered %0d touches and %0d releases over %0d capacity settings;",
             n_touch, n_release, n_cap_settings);
    $display("%0d hits, %0d evictions, %0d failures.", n_hit, n_evict, n_fail);
    if (n_fail == 0) begin
      $display("lru_pool_tag_table_top_test passed");
    end else begin
      $display("lru_pool_tag_table_top_test failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(RUN_LIMIT_NS);
    $display("lru_pool_tag_table_top_test failed");
    $finish;
  end

endmodule
